FILE: hdl/tcbt_pkg.sv
package tcbt_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int POS_BITS    = 16;
   localparam int ADDR_BITS   = $clog2(MAX_COLUMNS);
   localparam int CNT_BITS    = ADDR_BITS + 1;
   localparam int SPACE_BITS  = 16;
   localparam int TAB_BITS    = 5;
   localparam int CHAR_BITS   = 8;
   localparam int LEAD_BITS   = 2;

   localparam logic [TAB_BITS-1:0]  TAB_RESET = TAB_BITS'(8);

   localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_PRINT_LO = 8'h21;
   localparam logic [CHAR_BITS-1:0] CH_PRINT_HI = 8'h7E;

   localparam logic OP_LEARN   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   localparam logic [LEAD_BITS-1:0] LEAD_NONE   = 2'd0;
   localparam logic [LEAD_BITS-1:0] LEAD_TAB    = 2'd1;
   localparam logic [LEAD_BITS-1:0] LEAD_SPACES = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_FIX,
      ST_DONE
   } state_type;

   function automatic logic is_printable(input logic [CHAR_BITS-1:0] c);
      return c inside {[CH_PRINT_LO:CH_PRINT_HI]};
   endfunction

   function automatic logic [TAB_BITS-1:0] blank_advance(input logic [CHAR_BITS-1:0] c,
                                                        input logic [TAB_BITS-1:0] tw);
      logic [TAB_BITS-1:0] adv;
      adv = '0;
      if (c == CH_TAB) begin
         adv = tw;
      end else if (c == CH_SPACE) begin
         adv = TAB_BITS'(1);
      end
      return adv;
   endfunction

endpackage

FILE: hdl/text_column_boundary_to_tab.sv
// Text column boundary to tab converter.
//
// req_ channel: one word per text byte, req_op selects learn (sample line) or
// convert. rsp_ channel: exactly one word per request word, in order.
// csr_ channel: writes tab_width; always ready, write only while idle.
//
// A request is taken only in the idle state. For convert bytes and most learn
// bytes the word passes through the execute and handoff states before the
// response is valid; handoff waits until the output register is free, and the
// next word is taken once the block is back in idle. A learn word start on a
// later sample line walks the column table in memory: a read and a compare
// state per entry read (each entry below the word start and the first entry
// not below it), a read and a write state per entry moved down when entries
// are dropped, then a fix state, as the table memory read is registered.
// The response sits in an output register, so the next request is accepted
// while it waits; a stalled receiver holds the block only when a second
// response is ready to hand off. Synchronous reset clears state, column and
// space counts, line positions, line and error flags, sets tab_width to 8;
// the table memory is not cleared; only entries below the column count are read.
module text_column_boundary_to_tab (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [tcbt_pkg::CHAR_BITS-1:0]  req_char_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_emit,
   output logic [tcbt_pkg::LEAD_BITS-1:0]  rsp_lead_kind,
   output logic [tcbt_pkg::SPACE_BITS-1:0] rsp_lead_count,
   output logic [tcbt_pkg::CHAR_BITS-1:0]  rsp_out_char,
   output logic                            rsp_overflow_error,
   output logic [tcbt_pkg::CNT_BITS-1:0]   rsp_column_total,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tcbt_pkg::TAB_BITS-1:0]   csr_tab_width
);
   import tcbt_pkg::*;

   state_type state_ff, state_in;

   logic [TAB_BITS-1:0]   tab_width_ff;
   logic                  op_ff;
   logic [CHAR_BITS-1:0]  char_ff;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   conf_ff, conf_in;
   logic [POS_BITS-1:0]   lpos_ff, lpos_in;
   logic                  gap_ff, gap_in;
   logic                  first_ff, first_in;
   logic                  err_ff, err_in;
   logic [POS_BITS-1:0]   cpos_ff, cpos_in;
   logic [CNT_BITS-1:0]   next_ff, next_in;
   logic [SPACE_BITS-1:0] pend_ff, pend_in;

   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [CNT_BITS-1:0]   src_ff, src_in;
   logic [CNT_BITS-1:0]   dst_ff, dst_in;
   logic [CNT_BITS-1:0]   removed_ff, removed_in;
   logic                  hit_ff, hit_in;

   logic                  res_emit_ff, res_emit_in;
   logic [LEAD_BITS-1:0]  res_kind_ff, res_kind_in;
   logic [SPACE_BITS-1:0] res_cnt_ff, res_cnt_in;
   logic [CHAR_BITS-1:0]  res_char_ff, res_char_in;

   logic                  rsp_valid_ff;
   logic                  rsp_emit_ff;
   logic [LEAD_BITS-1:0]  rsp_kind_ff;
   logic [SPACE_BITS-1:0] rsp_cnt_ff;
   logic [CHAR_BITS-1:0]  rsp_char_ff;
   logic                  rsp_err_ff;
   logic [CNT_BITS-1:0]   rsp_total_ff;

   logic [POS_BITS-1:0]   mem [MAX_COLUMNS];
   logic [POS_BITS-1:0]   rd_data_ff;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [POS_BITS-1:0]   wr_data;

   logic                  req_fire;
   logic                  out_free;
   logic                  is_print;
   logic                  is_nl;
   logic [TAB_BITS-1:0]   adv;
   logic [POS_BITS:0]     lpos_sum;
   logic [POS_BITS:0]     cpos_sum;
   logic [SPACE_BITS:0]   pend_sum;
   logic [POS_BITS-1:0]   lpos_adv;
   logic [POS_BITS-1:0]   cpos_adv;
   logic [SPACE_BITS-1:0] pend_adv;
   logic                  word_start;
   logic                  need_scan;
   logic                  scan_less;
   logic                  scan_more;
   logic [CNT_BITS-1:0]   scan_inc;
   logic [CNT_BITS-1:0]   stop_idx;
   logic [CNT_BITS-1:0]   src_inc;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign is_print = is_printable(char_ff);
   assign is_nl    = (char_ff == CH_NEWLINE);
   assign adv      = is_print ? TAB_BITS'(1) : blank_advance(char_ff, tab_width_ff);
   assign lpos_sum = {1'b0, lpos_ff} + (POS_BITS+1)'(adv);
   assign cpos_sum = {1'b0, cpos_ff} + (POS_BITS+1)'(adv);
   assign pend_sum = {1'b0, pend_ff} + (SPACE_BITS+1)'(adv);
   assign lpos_adv = lpos_sum[POS_BITS] ? '1 : lpos_sum[POS_BITS-1:0];
   assign cpos_adv = cpos_sum[POS_BITS] ? '1 : cpos_sum[POS_BITS-1:0];
   assign pend_adv = pend_sum[SPACE_BITS] ? '1 : pend_sum[SPACE_BITS-1:0];

   assign word_start = (op_ff == OP_LEARN) && is_print && gap_ff;
   assign need_scan  = word_start && first_ff && (conf_ff < count_ff);

   assign scan_less = (rd_data_ff < pos_ff);
   assign scan_inc  = src_ff + CNT_BITS'(1);
   assign scan_more = scan_less && (scan_inc < count_ff);
   assign stop_idx  = scan_less ? scan_inc : src_ff;
   assign src_inc   = src_ff + CNT_BITS'(1);

   // table memory
   always_comb begin
      rd_addr = next_ff[ADDR_BITS-1:0];
      case (state_ff)
         ST_SCAN_RD: rd_addr = src_ff[ADDR_BITS-1:0];
         ST_MOVE_RD: rd_addr = src_ff[ADDR_BITS-1:0];
         default:    rd_addr = next_ff[ADDR_BITS-1:0];
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[ADDR_BITS-1:0];
      wr_data = lpos_adv;
      case (state_ff)
         ST_EXEC: begin
            wr_en = word_start && !first_ff && (count_ff < CNT_BITS'(MAX_COLUMNS));
         end
         ST_MOVE_WR: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[ADDR_BITS-1:0];
            wr_data = rd_data_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = need_scan ? ST_SCAN_RD : ST_DONE;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (scan_more) begin
               state_in = ST_SCAN_RD;
            end else if ((stop_idx < count_ff) && (stop_idx != conf_ff)) begin
               state_in = ST_MOVE_RD;
            end else begin
               state_in = ST_FIX;
            end
         end
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         ST_MOVE_WR: begin
            state_in = (src_inc < count_ff) ? ST_MOVE_RD : ST_FIX;
         end
         ST_FIX: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      count_in    = count_ff;
      conf_in     = conf_ff;
      lpos_in     = lpos_ff;
      gap_in      = gap_ff;
      first_in    = first_ff;
      err_in      = err_ff;
      cpos_in     = cpos_ff;
      next_in     = next_ff;
      pend_in     = pend_ff;
      pos_in      = pos_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      removed_in  = removed_ff;
      hit_in      = hit_ff;
      res_emit_in = res_emit_ff;
      res_kind_in = res_kind_ff;
      res_cnt_in  = res_cnt_ff;
      res_char_in = res_char_ff;
      case (state_ff)
         ST_EXEC: begin
            res_emit_in = 1'b0;
            res_kind_in = LEAD_NONE;
            res_cnt_in  = '0;
            res_char_in = '0;
            if (op_ff == OP_LEARN) begin
               if (is_nl) begin
                  lpos_in  = '0;
                  gap_in   = 1'b0;
                  conf_in  = '0;
                  first_in = 1'b1;
               end else if (is_print) begin
                  lpos_in = lpos_adv;
                  if (gap_ff) begin
                     gap_in = 1'b0;
                     if (!first_ff) begin
                        if (count_ff < CNT_BITS'(MAX_COLUMNS)) begin
                           count_in = count_ff + CNT_BITS'(1);
                        end else begin
                           err_in = 1'b1;
                        end
                     end
                  end
                  pos_in = lpos_adv;
                  src_in = conf_ff;
                  hit_in = 1'b0;
               end else begin
                  lpos_in = lpos_adv;
                  gap_in  = 1'b1;
               end
            end else begin
               if (is_print) begin
                  cpos_in     = cpos_adv;
                  res_emit_in = 1'b1;
                  res_char_in = char_ff;
                  if ((next_ff < count_ff) && (cpos_adv >= rd_data_ff)) begin
                     res_kind_in = LEAD_TAB;
                     next_in     = next_ff + CNT_BITS'(1);
                  end else if (pend_ff != '0) begin
                     res_kind_in = LEAD_SPACES;
                     res_cnt_in  = pend_ff;
                  end
                  pend_in = '0;
               end else if (is_nl) begin
                  res_emit_in = 1'b1;
                  res_char_in = char_ff;
                  cpos_in     = '0;
                  next_in     = '0;
                  pend_in     = '0;
               end else begin
                  cpos_in = cpos_adv;
                  pend_in = pend_adv;
               end
            end
         end
         ST_SCAN_CMP: begin
            src_in = stop_idx;
            if (!scan_more) begin
               dst_in     = conf_ff;
               removed_in = stop_idx - conf_ff;
               hit_in     = !scan_less && (rd_data_ff == pos_ff);
            end
         end
         ST_MOVE_WR: begin
            src_in = src_inc;
            dst_in = dst_ff + CNT_BITS'(1);
         end
         ST_FIX: begin
            count_in = count_ff - removed_ff;
            if (hit_ff) conf_in = conf_ff + CNT_BITS'(1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tab_width_ff <= TAB_RESET;
         count_ff     <= '0;
         conf_ff      <= '0;
         lpos_ff      <= '0;
         gap_ff       <= 1'b0;
         first_ff     <= 1'b0;
         err_ff       <= 1'b0;
         cpos_ff      <= '0;
         next_ff      <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) tab_width_ff <= csr_tab_width;
         count_ff <= count_in;
         conf_ff  <= conf_in;
         lpos_ff  <= lpos_in;
         gap_ff   <= gap_in;
         first_ff <= first_in;
         err_ff   <= err_in;
         cpos_ff  <= cpos_in;
         next_ff  <= next_in;
         pend_ff  <= pend_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_op;
         char_ff <= req_char_in;
      end
      pos_ff      <= pos_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      removed_ff  <= removed_in;
      hit_ff      <= hit_in;
      res_emit_ff <= res_emit_in;
      res_kind_ff <= res_kind_in;
      res_cnt_ff  <= res_cnt_in;
      res_char_ff <= res_char_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_emit_ff  <= res_emit_ff;
         rsp_kind_ff  <= res_kind_ff;
         rsp_cnt_ff   <= res_cnt_ff;
         rsp_char_ff  <= res_char_ff;
         rsp_err_ff   <= err_ff;
         rsp_total_ff <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_emit           = rsp_emit_ff;
   assign rsp_lead_kind      = rsp_kind_ff;
   assign rsp_lead_count     = rsp_cnt_ff;
   assign rsp_out_char       = rsp_char_ff;
   assign rsp_overflow_error = rsp_err_ff;
   assign rsp_column_total   = rsp_total_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_COLUMNS))
      else $error("column count beyond table depth");

   a_conf_le_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (conf_ff <= count_ff))
      else $error("confirmed count above column count");

   a_move_src: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE_WR) |-> ((src_ff < count_ff) && (dst_ff < src_ff)))
      else $error("compaction move out of range");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted word not executed");

endmodule
